>>> rtl/extended_euclid_gcd_defines.svh
// Assertion macros shared by the extended Euclid GCD unit.
`ifndef EXTENDED_EUCLID_GCD_DEFINES_SVH
`define EXTENDED_EUCLID_GCD_DEFINES_SVH

`ifndef SYNTH
`define EEG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EEG_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define EEG_ASSERT(lbl, prop, msg)
`define EEG_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> rtl/eeg_pkg.sv
// Package with widths and controller/datapath interface types of the GCD unit.
`timescale 1ns / 1ps
`default_nettype none
package eeg_pkg;
  localparam int WIDTH      = 32;
  localparam int COEF_W     = WIDTH + 1;
  localparam int CNT_W      = $clog2(WIDTH);
  localparam int IN_DATA_W  = ((2 * WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((WIDTH + 2 * COEF_W + 7) / 8) * 8;

  typedef struct packed {
    logic load;
    logic start_div;
    logic div_step;
    logic update;
    logic commit;
  } eeg_cmd_t;

  typedef struct packed {
    logic r1_zero;
  } eeg_status_t;
endpackage
`default_nettype wire

>>> rtl/extended_euclid_gcd.sv
// Top level of the extended Euclid GCD unit: controller, datapath and checks.
//
//   Channel  Direction  Payload (lowest bit up)
//   in_      slave      operand_a[31:0], operand_b[63:32]
//   out_     master     divisor[31:0], coeff_a[64:32], coeff_b[97:65], zero fill
//
// Each Euclid step runs the bit-serial restoring divider, one quotient bit per
// cycle, which also builds the quotient-times-coefficient products.
// Reset is synchronous and clears only the controller state and the output valid.
// A new beat is taken while a finished result still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "extended_euclid_gcd_defines.svh"
module extended_euclid_gcd
  import eeg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // operand_a, operand_b
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata   // divisor, coeff_a, coeff_b
);
  eeg_cmd_t    cmd;
  eeg_status_t status;

  eeg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .status     (status),
    .cmd        (cmd)
  );

  eeg_datapath u_datapath (
    .clk       (clk),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (out_tdata)
  );

  `EEG_ASSERT(a_busy_after_accept, (in_tvalid && in_tready) |=> !in_tready, "accepted while busy")
  `EEG_ASSERT(a_commit_sets_valid, cmd.commit |=> out_tvalid, "result lost after commit")
  `EEG_ASSERT_NEVER(a_cmd_exclusive, !$onehot0(cmd), "overlapping datapath commands")
  `EEG_ASSERT(a_drain_clears, (out_tvalid && out_tready && !cmd.commit) |=> !out_tvalid,
              "result beat repeated")
endmodule
`default_nettype wire

>>> rtl/eeg_ctrl.sv
// Controller state machine that sequences the Euclid steps and the bit-serial divider.
`timescale 1ns / 1ps
`default_nettype none
module eeg_ctrl
  import eeg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic        out_tready,
  output logic             out_tvalid,
  input  wire eeg_status_t status,
  output eeg_cmd_t         cmd
);
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_UPD   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.r1_zero) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.start_div = 1'b1;
          cnt_nxt       = CNT_W'(WIDTH - 1);
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = ST_CHECK;
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
endmodule
`default_nettype wire

>>> rtl/eeg_datapath.sv
// Datapath with remainder and coefficient registers and a one-bit-per-cycle divider.
`timescale 1ns / 1ps
`default_nettype none
module eeg_datapath
  import eeg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire eeg_cmd_t              cmd,
  output eeg_status_t                status,
  output logic      [OUT_DATA_W-1:0] out_tdata
);
  logic [WIDTH-1:0]  r0_r, r0_nxt, r1_r, r1_nxt;
  logic [COEF_W-1:0] s0_r, s0_nxt, s1_r, s1_nxt;
  logic [COEF_W-1:0] t0_r, t0_nxt, t1_r, t1_nxt;
  logic [WIDTH-1:0]  rem_r, rem_nxt, dvd_r, dvd_nxt;
  logic [COEF_W-1:0] acc_s_r, acc_s_nxt, acc_t_r, acc_t_nxt;
  logic [WIDTH-1:0]  gcd_out_r;
  logic [COEF_W-1:0] coef_a_out_r, coef_b_out_r;
  logic [WIDTH:0]    shifted;
  logic [WIDTH:0]    trial;
  logic              qbit;

  assign shifted = {rem_r, dvd_r[WIDTH-1]};
  assign trial   = shifted - {1'b0, r1_r};
  assign qbit    = !trial[WIDTH];

  always_comb begin
    r0_nxt    = r0_r;
    r1_nxt    = r1_r;
    s0_nxt    = s0_r;
    s1_nxt    = s1_r;
    t0_nxt    = t0_r;
    t1_nxt    = t1_r;
    rem_nxt   = rem_r;
    dvd_nxt   = dvd_r;
    acc_s_nxt = acc_s_r;
    acc_t_nxt = acc_t_r;
    if (cmd.load) begin
      r0_nxt = in_tdata[WIDTH-1:0];
      r1_nxt = in_tdata[2*WIDTH-1:WIDTH];
      s0_nxt = COEF_W'(1);
      s1_nxt = '0;
      t0_nxt = '0;
      t1_nxt = COEF_W'(1);
    end
    if (cmd.start_div) begin
      rem_nxt   = '0;
      dvd_nxt   = r0_r;
      acc_s_nxt = '0;
      acc_t_nxt = '0;
    end
    if (cmd.div_step) begin
      rem_nxt   = qbit ? trial[WIDTH-1:0] : shifted[WIDTH-1:0];
      dvd_nxt   = {dvd_r[WIDTH-2:0], 1'b0};
      acc_s_nxt = {acc_s_r[COEF_W-2:0], 1'b0} + (qbit ? s1_r : '0);
      acc_t_nxt = {acc_t_r[COEF_W-2:0], 1'b0} + (qbit ? t1_r : '0);
    end
    if (cmd.update) begin
      r0_nxt = r1_r;
      r1_nxt = rem_r;
      s0_nxt = s1_r;
      s1_nxt = s0_r - acc_s_r;
      t0_nxt = t1_r;
      t1_nxt = t0_r - acc_t_r;
    end
  end

  always_ff @(posedge clk) begin
    r0_r    <= r0_nxt;
    r1_r    <= r1_nxt;
    s0_r    <= s0_nxt;
    s1_r    <= s1_nxt;
    t0_r    <= t0_nxt;
    t1_r    <= t1_nxt;
    rem_r   <= rem_nxt;
    dvd_r   <= dvd_nxt;
    acc_s_r <= acc_s_nxt;
    acc_t_r <= acc_t_nxt;
    if (cmd.commit) begin
      gcd_out_r    <= r0_r;
      coef_a_out_r <= s0_r;
      coef_b_out_r <= t0_r;
    end
  end

  assign status.r1_zero = (r1_r == '0);
  assign out_tdata      = OUT_DATA_W'({coef_b_out_r, coef_a_out_r, gcd_out_r});
endmodule
`default_nettype wire
